>>> rtl/vds_pkg.sv
package vds_pkg;

	localparam int ID_W    = 6;
	localparam int POS_W   = 32;
	localparam int DIR_W   = 16;
	localparam int DEPTH_W = 50;
	localparam int CFG_IDX_W = 3;

	localparam logic [DIR_W-1:0] DIR_Z_RST = 16'd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAM_X = 3'd0,
		REG_CAM_Y = 3'd1,
		REG_CAM_Z = 3'd2,
		REG_DIR_X = 3'd3,
		REG_DIR_Y = 3'd4,
		REG_DIR_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [POS_W-1:0] cam_x;
		logic [POS_W-1:0] cam_y;
		logic [POS_W-1:0] cam_z;
		logic [DIR_W-1:0] dir_x;
		logic [DIR_W-1:0] dir_y;
		logic [DIR_W-1:0] dir_z;
	} view_cfg_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [DEPTH_W-1:0] depth;
	} rec_t;

	typedef struct packed {
		logic ins;
		logic drain;
	} cell_ctrl_t;

endpackage

>>> rtl/vds_depth.sv
module vds_depth (
	input  logic                     clk,
	input  logic                     arst_n,
	input  vds_pkg::view_cfg_t       cfg,
	input  logic                     in_valid,
	input  logic [vds_pkg::ID_W-1:0] in_id,
	input  logic [vds_pkg::POS_W-1:0] in_x,
	input  logic [vds_pkg::POS_W-1:0] in_y,
	input  logic [vds_pkg::POS_W-1:0] in_z,
	input  logic                     in_last,
	output logic                     rec_valid,
	output vds_pkg::rec_t            rec,
	output logic                     rec_last
);
	import vds_pkg::*;

	localparam int DIFF_W = POS_W + 1;
	localparam int PROD_W = DIFF_W + DIR_W;
	localparam int SUM_W  = PROD_W + 2;

	logic                     valid_s1, valid_s2, valid_s3;
	logic                     last_s1, last_s2, last_s3;
	logic [ID_W-1:0]          id_s1, id_s2, id_s3;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [PROD_W-1:0] px_s2, py_s2, pz_s2;
	logic [DEPTH_W-1:0]       depth_s3;
	logic signed [SUM_W-1:0]  sum;

	assign sum = SUM_W'(px_s2) + SUM_W'(py_s2) + SUM_W'(pz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: offset from camera
		id_s1   <= in_id;
		last_s1 <= in_last;
		dx_s1   <= $signed({in_x[POS_W-1], in_x}) - $signed({cfg.cam_x[POS_W-1], cfg.cam_x});
		dy_s1   <= $signed({in_y[POS_W-1], in_y}) - $signed({cfg.cam_y[POS_W-1], cfg.cam_y});
		dz_s1   <= $signed({in_z[POS_W-1], in_z}) - $signed({cfg.cam_z[POS_W-1], cfg.cam_z});
		// stage 2: products
		id_s2   <= id_s1;
		last_s2 <= last_s1;
		px_s2   <= dx_s1 * $signed(cfg.dir_x);
		py_s2   <= dy_s1 * $signed(cfg.dir_y);
		pz_s2   <= dz_s1 * $signed(cfg.dir_z);
		// stage 3: sum, always fits the depth width
		id_s3    <= id_s2;
		last_s3  <= last_s2;
		depth_s3 <= sum[DEPTH_W-1:0];
	end

	assign rec_valid = valid_s3;
	assign rec_last  = last_s3;
	assign rec.id    = id_s3;
	assign rec.depth = depth_s3;

endmodule

>>> rtl/vds_cell.sv
module vds_cell (
	input  logic                clk,
	input  vds_pkg::cell_ctrl_t ctrl,
	input  vds_pkg::rec_t       new_rec,
	input  vds_pkg::rec_t       left_rec,
	input  vds_pkg::rec_t       right_rec,
	input  logic                left_keep,
	input  logic                filled,
	output vds_pkg::rec_t       rec,
	output logic                keep
);
	import vds_pkg::*;

	rec_t rec_q;

	// farther or equal entries stay, which keeps equal depths in load order
	assign keep = filled && ($signed(rec_q.depth) >= $signed(new_rec.depth));
	assign rec  = rec_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!keep) begin
				rec_q <= left_keep ? new_rec : left_rec;
			end
		end else if (ctrl.drain) begin
			rec_q <= right_rec;
		end
	end

endmodule

>>> rtl/view_depth_sort_unit.sv
// View depth sort. Each object accepted on start (while busy is low) gets its
// depth, (pos - cam) dot dir, in a three-stage pipeline and is then placed in
// a chain of MAX_OBJECTS sorting cells, so one object can be accepted every
// cycle. Busy rises after the object marked last_obj is accepted; once that
// object leaves the pipeline the chain shifts out its N stored records back to
// back, farthest first, one result per strobe cycle, and busy falls as the
// final result (last_out) is registered. The receiver cannot stall: every
// result is on the outputs for exactly one cycle. Objects that arrive with the
// chain full are dropped and overflowed is set on that frame's results.
// Configuration writes are always ready.
module view_depth_sort_unit #(
	parameter int MAX_OBJECTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [vds_pkg::ID_W-1:0]     obj_id,
	input  logic [vds_pkg::POS_W-1:0]    pos_x,
	input  logic [vds_pkg::POS_W-1:0]    pos_y,
	input  logic [vds_pkg::POS_W-1:0]    pos_z,
	input  logic                         last_obj,
	output logic                         strobe,
	output logic [vds_pkg::ID_W-1:0]     sorted_id,
	output logic [vds_pkg::DEPTH_W-1:0]  depth,
	output logic                         overflowed,
	output logic                         last_out,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [vds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vds_pkg::POS_W-1:0]    cfg_data
);
	import vds_pkg::*;

	localparam int CNT_W = $clog2(MAX_OBJECTS + 1);

	view_cfg_t          cfg_q;
	logic               accept;
	logic               rec_valid, rec_last;
	rec_t               rec;
	logic [CNT_W-1:0]   count_q;
	logic               full;
	logic               busy_q, drain_q, drop_q;
	cell_ctrl_t         ctrl;
	rec_t               cell_rec  [MAX_OBJECTS];
	logic               cell_keep [MAX_OBJECTS];
	logic               strobe_q, overflowed_q, last_out_q;
	logic [ID_W-1:0]    sorted_id_q;
	logic [DEPTH_W-1:0] depth_q;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy_q;
	assign full      = (count_q == CNT_W'(MAX_OBJECTS));
	assign ctrl.ins   = rec_valid && !full;
	assign ctrl.drain = drain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cam_x <= '0;
			cfg_q.cam_y <= '0;
			cfg_q.cam_z <= '0;
			cfg_q.dir_x <= '0;
			cfg_q.dir_y <= '0;
			cfg_q.dir_z <= DIR_Z_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAM_X: cfg_q.cam_x <= cfg_data;
				REG_CAM_Y: cfg_q.cam_y <= cfg_data;
				REG_CAM_Z: cfg_q.cam_z <= cfg_data;
				REG_DIR_X: cfg_q.dir_x <= cfg_data[DIR_W-1:0];
				REG_DIR_Y: cfg_q.dir_y <= cfg_data[DIR_W-1:0];
				REG_DIR_Z: cfg_q.dir_z <= cfg_data[DIR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	vds_depth u_depth (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (accept),
		.in_id    (obj_id),
		.in_x     (pos_x),
		.in_y     (pos_y),
		.in_z     (pos_z),
		.in_last  (last_obj),
		.rec_valid(rec_valid),
		.rec      (rec),
		.rec_last (rec_last)
	);

	for (genvar k = 0; k < MAX_OBJECTS; k++) begin : g_cell
		localparam logic [CNT_W-1:0] POS = CNT_W'(k);
		rec_t left_rec, right_rec;
		logic left_keep;

		if (k == 0) begin : g_head
			assign left_rec  = rec;
			assign left_keep = 1'b1;
		end else begin : g_body
			assign left_rec  = cell_rec[k-1];
			assign left_keep = cell_keep[k-1];
		end

		if (k == MAX_OBJECTS - 1) begin : g_tail
			assign right_rec = cell_rec[k];
		end else begin : g_mid
			assign right_rec = cell_rec[k+1];
		end

		vds_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.new_rec  (rec),
			.left_rec (left_rec),
			.right_rec(right_rec),
			.left_keep(left_keep),
			.filled   (POS < count_q),
			.rec      (cell_rec[k]),
			.keep     (cell_keep[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			busy_q   <= 1'b0;
			drain_q  <= 1'b0;
			drop_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (accept && last_obj) begin
				busy_q <= 1'b1;
			end
			if (rec_valid) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
				if (rec_last) begin
					drain_q <= 1'b1;
				end
			end
			if (drain_q) begin
				strobe_q <= 1'b1;
				count_q  <= count_q - CNT_W'(1);
				if (count_q <= CNT_W'(1)) begin
					drain_q <= 1'b0;
					drop_q  <= 1'b0;
					busy_q  <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain_q) begin
			sorted_id_q  <= cell_rec[0].id;
			depth_q      <= cell_rec[0].depth;
			overflowed_q <= drop_q;
			last_out_q   <= (count_q <= CNT_W'(1));
		end
	end

	assign busy       = busy_q;
	assign strobe     = strobe_q;
	assign sorted_id  = sorted_id_q;
	assign depth      = depth_q;
	assign overflowed = overflowed_q;
	assign last_out   = last_out_q;

	a_drain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> busy_q)
		else $error("drain without busy");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_OBJECTS))
		else $error("record count beyond capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> count_q != '0)
		else $error("drain of an empty chain");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_out_q) |-> !busy_q)
		else $error("busy still high at final result");

	a_no_insert_drain: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> !rec_valid)
		else $error("record arrives while draining");

endmodule

>>> tb/tb_top.sv
module tb_top;
	import vds_pkg::*;

	localparam int MAX_OBJ = 64;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct {
		logic [ID_W-1:0]  id;
		logic [POS_W-1:0] pos[3];
		logic             fin;
	} obj_t;

	typedef struct {
		logic [ID_W-1:0] id;
		longint          d;
	} placed_t;

	typedef struct {
		logic [ID_W-1:0]    id;
		logic [DEPTH_W-1:0] d;
		logic               ovf;
		logic               fin;
	} sorted_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [ID_W-1:0]      obj_id = '0;
	logic [POS_W-1:0]     pos_x = '0;
	logic [POS_W-1:0]     pos_y = '0;
	logic [POS_W-1:0]     pos_z = '0;
	logic                 last_obj = 1'b0;
	logic                 strobe;
	logic [ID_W-1:0]      sorted_id;
	logic [DEPTH_W-1:0]   depth;
	logic                 overflowed;
	logic                 last_out;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [POS_W-1:0]     cfg_data = '0;

	obj_t    pending_objs[$];
	placed_t frame_recs[$];
	sorted_t due_results[$];
	obj_t    drv_item;
	logic    frame_dropped = 1'b0;
	logic signed [POS_W-1:0] cam_pos[3];
	logic signed [DIR_W-1:0] view_dir[3];
	int      objs_queued = 0;
	int      objs_taken = 0;
	int      gen_open = 0;
	int      idle_pct = 37;
	int      fail_cnt = 0;

	cfg_reg_t all_regs[6] = '{REG_CAM_X, REG_CAM_Y, REG_CAM_Z, REG_DIR_X, REG_DIR_Y, REG_DIR_Z};

	view_depth_sort_unit #(.MAX_OBJECTS(MAX_OBJ)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.obj_id(obj_id),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.last_obj(last_obj),
		.strobe(strobe),
		.sorted_id(sorted_id),
		.depth(depth),
		.overflowed(overflowed),
		.last_out(last_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void set_view(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] data);
		case (idx)
			REG_CAM_X: cam_pos[0] = data;
			REG_CAM_Y: cam_pos[1] = data;
			REG_CAM_Z: cam_pos[2] = data;
			REG_DIR_X: view_dir[0] = data[DIR_W-1:0];
			REG_DIR_Y: view_dir[1] = data[DIR_W-1:0];
			REG_DIR_Z: view_dir[2] = data[DIR_W-1:0];
			default: ;
		endcase
	endfunction

	// depth at load time, stable insertion far to near, drain on frame end
	function automatic void sort_in_object(input obj_t it);
		longint  d;
		int      k;
		int      a;
		placed_t r;
		sorted_t s;
		d = 0;
		for (a = 0; a < 3; a++)
			d += (longint'($signed(it.pos[a])) - longint'(cam_pos[a])) * longint'(view_dir[a]);
		if (frame_recs.size() < MAX_OBJ) begin
			k = frame_recs.size();
			while (k > 0 && frame_recs[k-1].d < d)
				k--;
			r.id = it.id;
			r.d = d;
			frame_recs.insert(k, r);
		end else begin
			frame_dropped = 1'b1;
		end
		if (it.fin) begin
			foreach (frame_recs[i]) begin
				s.id = frame_recs[i].id;
				s.d = frame_recs[i].d[DEPTH_W-1:0];
				s.ovf = frame_dropped;
				s.fin = (i == frame_recs.size() - 1);
				due_results.push_back(s);
			end
			frame_recs.delete();
			frame_dropped = 1'b0;
		end
		objs_taken++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				sort_in_object(drv_item);
			if (!(start && busy)) begin
				if (pending_objs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					drv_item = pending_objs.pop_front();
					start <= 1'b1;
					obj_id <= drv_item.id;
					pos_x <= drv_item.pos[0];
					pos_y <= drv_item.pos[1];
					pos_z <= drv_item.pos[2];
					last_obj <= drv_item.fin;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		sorted_t e;
		if (arst_n && strobe) begin
			if (due_results.size() == 0) begin
				$display("%0t unexpected result: expected none, got id %0d depth %0d", $time,
					sorted_id, $signed(depth));
				fail_cnt++;
			end else begin
				e = due_results.pop_front();
				if (sorted_id !== e.id) begin
					$display("%0t sorted_id: expected %0d, got %0d", $time, e.id, sorted_id);
					fail_cnt++;
				end
				if (depth !== e.d) begin
					$display("%0t depth: expected %0d, got %0d", $time, $signed(e.d),
						$signed(depth));
					fail_cnt++;
				end
				if (overflowed !== e.ovf) begin
					$display("%0t overflowed: expected %0b, got %0b", $time, e.ovf, overflowed);
					fail_cnt++;
				end
				if (last_out !== e.fin) begin
					$display("%0t last_out: expected %0b, got %0b", $time, e.fin, last_out);
					fail_cnt++;
				end
			end
		end
	end

	function automatic void push_obj(input logic [ID_W-1:0] id, input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] y, input logic [POS_W-1:0] z, input logic fin);
		obj_t it;
		it.id = id;
		it.pos[0] = x;
		it.pos[1] = y;
		it.pos[2] = z;
		it.fin = fin;
		pending_objs.push_back(it);
		objs_queued++;
		gen_open = fin ? 0 : gen_open + 1;
	endfunction

	function automatic logic [POS_W-1:0] rand_pos();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return 32'($urandom_range(0, 3)) << 16;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DIR_W-1:0] rand_dir();
		case ($urandom_range(0, 6))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h4000;
			3: return 16'hc000;
			4: return '0;
			5: return 16'(int'($urandom_range(0, 32768)) - 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void push_rand(input logic fin);
		push_obj(ID_W'($urandom_range(0, 63)), rand_pos(), rand_pos(), rand_pos(), fin);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		set_view(idx, data);
	endtask

	task automatic settle();
		while (objs_taken != objs_queued || due_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		int p;
		int n;
		int small_cnt;
		cam_pos = '{0, 0, 0};
		view_dir = '{0, 0, $signed(DIR_Z_RST)};
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// reset view: depth follows pos_z, ties keep load order
		push_obj(6'd0, 32'h0, 32'h0, 32'h0, 1'b1);
		push_obj(6'd63, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
		push_obj(6'd1, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 1'b0);
		push_obj(6'd2, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		push_obj(6'd3, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		settle();

		write_reg(REG_CAM_X, 32'h8000_0000);
		write_reg(REG_CAM_Y, 32'h8000_0000);
		write_reg(REG_CAM_Z, 32'h8000_0000);
		write_reg(REG_DIR_X, 32'hffff_7fff);
		write_reg(REG_DIR_Y, 32'h0000_8000);
		write_reg(REG_DIR_Z, 32'h0000_4000);
		push_obj(6'd10, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		push_obj(6'd11, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		push_obj(6'd12, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
		settle();

		write_reg(REG_CAM_X, 32'h7fff_ffff);
		write_reg(REG_CAM_Y, 32'h7fff_ffff);
		write_reg(REG_CAM_Z, 32'h7fff_ffff);
		write_reg(REG_DIR_X, 32'h0000_c000);
		write_reg(REG_DIR_Y, 32'h0000_4000);
		write_reg(REG_DIR_Z, 32'h0000_8000);
		push_obj(6'd20, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
		push_obj(6'd21, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		push_obj(6'd22, 32'h0, 32'h0001_0000, 32'hffff_0000, 1'b1);
		settle();

		// all-zero direction, every depth ties
		write_reg(REG_DIR_X, 32'h0);
		write_reg(REG_DIR_Y, 32'h0);
		write_reg(REG_DIR_Z, 32'h0);
		write_reg(REG_SPARE_6, 32'h0000_7fff);
		write_reg(REG_SPARE_7, 32'hffff_ffff);
		push_obj(6'd5, 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
		push_obj(6'd4, 32'h0, 32'h0, 32'h0, 1'b0);
		push_obj(6'd3, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
		push_obj(6'd2, 32'h0abc_def0, 32'h0, 32'h1, 1'b1);
		settle();

		p = 0;
		small_cnt = 0;
		while (small_cnt < 60 || p <= 5) begin
			foreach (all_regs[i]) begin
				if (p % 5 == 0 || $urandom_range(0, 1) == 1) begin
					if (all_regs[i] inside {REG_CAM_X, REG_CAM_Y, REG_CAM_Z})
						write_reg(all_regs[i], rand_pos());
					else
						write_reg(all_regs[i], {16'($urandom), rand_dir()});
				end
			end
			if ($urandom_range(0, 9) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
			idle_pct = (p % 6 == 3) ? 0 : 37;
			if (p == 2 || p == 5) begin
				// full store, then a frame whose tail and last record are dropped
				n = (p == 2) ? MAX_OBJ - 1 : MAX_OBJ + 1;
				while (gen_open < n)
					push_rand(1'b0);
				push_rand(1'b1);
			end else begin
				n = $urandom_range(1, 20);
				for (int j = 0; j < n; j++) begin
					if (j == n - 1)
						push_rand($urandom_range(0, 4) != 0);
					else
						push_rand($urandom_range(0, 4) == 0);
				end
				small_cnt += n;
			end
			settle();
			p++;
		end
		idle_pct = 37;
		if (gen_open != 0)
			push_rand(1'b1);
		settle();

		if (fail_cnt == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#400000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
